/* hdl/hms_pkg.sv */
// Shared widths, codes, constants, types and a helper function of the countdown timer.
package hms_pkg;

   localparam int unsigned HOUR_W      = 7;
   localparam int unsigned MIN_W       = 6;
   localparam int unsigned SEC_W       = 6;
   localparam int unsigned TICK_W      = 16;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned SEL_W       = 3;
   localparam int unsigned REQ_DATA_W  = 8;
   localparam int unsigned REQ_USER_W  = KIND_W;
   localparam int unsigned RSP_FIELD_W = HOUR_W + MIN_W + SEC_W + 1;
   localparam int unsigned RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [TICK_W-1:0] TPS_RESET = 16'd1000;

   localparam int unsigned HOUR_TENS_TOP = 90;
   localparam int unsigned MS_TENS_TOP   = 50;
   localparam int unsigned MS_RELOAD     = 59;
   localparam int unsigned HOUR_RELOAD   = (1 << HOUR_W) - 1;

   localparam logic [HOUR_W-1:0] DIGIT_BASE = 7'd10;

   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UP     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd3;

   localparam logic [SEL_W-1:0] SEL_HOUR_TENS = 3'd0;
   localparam logic [SEL_W-1:0] SEL_HOUR_ONES = 3'd1;
   localparam logic [SEL_W-1:0] SEL_MIN_TENS  = 3'd2;
   localparam logic [SEL_W-1:0] SEL_MIN_ONES  = 3'd3;
   localparam logic [SEL_W-1:0] SEL_SEC_TENS  = 3'd4;
   localparam logic [SEL_W-1:0] SEL_SEC_ONES  = 3'd5;

   typedef struct packed {
      logic step;
      logic up;
      logic tens;
   } hms_cell_cmd_type;

   typedef struct packed {
      logic take_second;
      logic run_next;
   } hms_tick_status_type;

   // Ones digit of a value below 128, found by conditional subtraction.
   function automatic logic [3:0] ones_digit(input logic [HOUR_W-1:0] v);
      logic [HOUR_W-1:0] r;
      r = v;
      if (r >= 7'd80) r = r - 7'd80;
      if (r >= 7'd40) r = r - 7'd40;
      if (r >= 7'd20) r = r - 7'd20;
      if (r >= 7'd10) r = r - 7'd10;
      return r[3:0];
   endfunction

endpackage

/* hdl/hms_countdown_timer.sv */
// Top level of the hours, minutes and seconds countdown timer.
//
// Each transfer on the req_ channel is one event: req_tuser carries the kind (tick,
// digit up, digit down, run toggle) and req_tdata the digit selector. Every event
// returns exactly one transfer on the rsp_ channel with the time and run state as
// they stand after the event. The time is kept by a chain of three cells (seconds,
// minutes, hours) that pass borrows down the chain; a tick controller beside them
// counts ticks against the ticks_per_second register, written over the csr_ channel.
// Users must write it only while the timer is idle; the block does not enforce it.
// Each response is registered in the result register, and one event is taken in every
// cycle while the receiver keeps rsp_tready high; the rate is set by the update of the
// cell chain, made combinationally for each event. A result register with one skid
// entry lets one more event enter while a response is stalled; with both full,
// req_tready drops until rsp_tready returns.
// Synchronous reset clears the time to zero, stops the timer, clears the tick count,
// loads a period of 1000 ticks and empties the response stage.
module hms_countdown_timer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Bits from the lowest up: digit_select.
   input  logic [hms_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Bits from the lowest up: kind.
   input  logic [hms_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Bits from the lowest up: hours, minutes, seconds, running.
   output logic [hms_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hms_pkg::TICK_W-1:0]         csr_data
);
   import hms_pkg::*;

   logic                    accept;
   logic [KIND_W-1:0]       kind;
   logic [SEL_W-1:0]        sel;
   logic                    is_step;
   logic                    is_up;
   hms_cell_cmd_type        hour_cmd;
   hms_cell_cmd_type        min_cmd;
   hms_cell_cmd_type        sec_cmd;
   hms_tick_status_type     status;
   logic [HOUR_W-1:0]       hour_next;
   logic [MIN_W-1:0]        min_next;
   logic [SEC_W-1:0]        sec_next;
   logic                    hour_zero;
   logic                    min_zero;
   logic                    sec_zero;
   logic                    sec_borrow;
   logic                    min_borrow;
   logic [RSP_FIELD_W-1:0]  result;
   logic [RSP_FIELD_W-1:0]  out_ff;
   logic [RSP_FIELD_W-1:0]  out_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [RSP_FIELD_W-1:0]  skid_ff;
   logic [RSP_FIELD_W-1:0]  skid_in;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   logic                    take_out;

   assign kind       = req_tuser[KIND_W-1:0];
   assign sel        = req_tdata[SEL_W-1:0];
   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign is_step = accept & ((kind == KIND_UP) || (kind == KIND_DOWN));
   assign is_up   = (kind == KIND_UP);

   assign hour_cmd.step = is_step & ((sel == SEL_HOUR_TENS) || (sel == SEL_HOUR_ONES));
   assign hour_cmd.up   = is_up;
   assign hour_cmd.tens = (sel == SEL_HOUR_TENS);
   assign min_cmd.step  = is_step & ((sel == SEL_MIN_TENS) || (sel == SEL_MIN_ONES));
   assign min_cmd.up    = is_up;
   assign min_cmd.tens  = (sel == SEL_MIN_TENS);
   assign sec_cmd.step  = is_step & ((sel == SEL_SEC_TENS) || (sel == SEL_SEC_ONES));
   assign sec_cmd.up    = is_up;
   assign sec_cmd.tens  = (sel == SEL_SEC_TENS);

   hms_tick_ctrl u_tick_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .accept    (accept),
      .kind      (kind),
      .time_zero (hour_zero & min_zero & sec_zero),
      .status    (status)
   );

   // A borrow moves on to the next cell when the current cell is at zero.
   assign sec_borrow = status.take_second & sec_zero;
   assign min_borrow = sec_borrow & min_zero;

   hms_digit_cell #(
      .WIDTH    (SEC_W),
      .TENS_TOP (MS_TENS_TOP),
      .RELOAD   (MS_RELOAD)
   ) u_sec_cell (
      .clock      (clock),
      .reset      (reset),
      .cmd        (sec_cmd),
      .borrow_in  (status.take_second),
      .value_next (sec_next),
      .zero       (sec_zero)
   );

   hms_digit_cell #(
      .WIDTH    (MIN_W),
      .TENS_TOP (MS_TENS_TOP),
      .RELOAD   (MS_RELOAD)
   ) u_min_cell (
      .clock      (clock),
      .reset      (reset),
      .cmd        (min_cmd),
      .borrow_in  (sec_borrow),
      .value_next (min_next),
      .zero       (min_zero)
   );

   hms_digit_cell #(
      .WIDTH    (HOUR_W),
      .TENS_TOP (HOUR_TENS_TOP),
      .RELOAD   (HOUR_RELOAD)
   ) u_hour_cell (
      .clock      (clock),
      .reset      (reset),
      .cmd        (hour_cmd),
      .borrow_in  (min_borrow),
      .value_next (hour_next),
      .zero       (hour_zero)
   );

   assign result = {status.run_next, sec_next, min_next, hour_next};

   assign take_out = out_valid_ff & rsp_tready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take_out) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take_out) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (take_out) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELD_W){1'b0}}, out_ff};

endmodule

/* hdl/hms_digit_cell.sv */
// One cell of the time chain: holds a two-digit field, applies digit steps and borrows.
module hms_digit_cell #(
   parameter int unsigned WIDTH    = hms_pkg::MIN_W,
   parameter int unsigned TENS_TOP = hms_pkg::MS_TENS_TOP,
   parameter int unsigned RELOAD   = hms_pkg::MS_RELOAD
) (
   input  logic                      clock,
   input  logic                      reset,
   input  hms_pkg::hms_cell_cmd_type cmd,
   input  logic                      borrow_in,
   output logic [WIDTH-1:0]          value_next,
   output logic                      zero
);
   import hms_pkg::*;

   localparam logic [HOUR_W-1:0] TOP7    = HOUR_W'(TENS_TOP);
   localparam logic [HOUR_W-1:0] RELOAD7 = HOUR_W'(RELOAD);

   logic [WIDTH-1:0]  value_ff;
   logic [WIDTH-1:0]  value_in;
   logic [HOUR_W-1:0] v7;
   logic [HOUR_W-1:0] n7;
   logic [3:0]        digit;

   assign zero       = (value_ff == '0);
   assign value_next = value_in;

   always_comb begin
      v7    = HOUR_W'(value_ff);
      digit = ones_digit(v7);
      n7    = v7;
      if (cmd.step) begin
         if (cmd.tens) begin
            if (cmd.up) begin
               n7 = (v7 >= TOP7) ? v7 - TOP7 : v7 + DIGIT_BASE;
            end else begin
               n7 = (v7 < DIGIT_BASE) ? v7 + TOP7 : v7 - DIGIT_BASE;
            end
         end else begin
            if (cmd.up) begin
               n7 = (digit == 4'd9) ? v7 - 7'd9 : v7 + 7'd1;
            end else begin
               n7 = (digit == 4'd0) ? v7 + 7'd9 : v7 - 7'd1;
            end
         end
      end else if (borrow_in) begin
         n7 = zero ? RELOAD7 : v7 - 7'd1;
      end
      value_in = WIDTH'(n7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

endmodule

/* hdl/hms_tick_ctrl.sv */
// Run flag, tick accumulator and period register that decide when a second is taken off.
module hms_tick_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [hms_pkg::TICK_W-1:0]   csr_data,
   input  logic                         accept,
   input  logic [hms_pkg::KIND_W-1:0]   kind,
   input  logic                         time_zero,
   output hms_pkg::hms_tick_status_type status
);
   import hms_pkg::*;

   logic [TICK_W-1:0] tps_ff;
   logic [TICK_W-1:0] tps_in;
   logic [TICK_W-1:0] accum_ff;
   logic [TICK_W-1:0] accum_in;
   logic [TICK_W-1:0] accum_inc;
   logic              run_ff;
   logic              run_in;
   logic              take;

   assign accum_inc = accum_ff + 16'd1;
   assign tps_in    = csr_write ? csr_data : tps_ff;

   always_comb begin
      run_in   = run_ff;
      accum_in = accum_ff;
      take     = 1'b0;
      if (accept) begin
         unique case (kind)
            KIND_TICK: begin
               run_in = run_ff & ~time_zero;
               if (run_in) begin
                  if (accum_inc >= tps_ff) begin
                     accum_in = '0;
                     take     = 1'b1;
                  end else begin
                     accum_in = accum_inc;
                  end
               end
            end
            KIND_UP, KIND_DOWN: begin
               run_in = run_ff;
            end
            KIND_TOGGLE: begin
               run_in = ~run_ff;
            end
         endcase
      end
      status.take_second = take;
      status.run_next    = run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff   <= TPS_RESET;
         accum_ff <= '0;
         run_ff   <= 1'b0;
      end else begin
         tps_ff   <= tps_in;
         accum_ff <= accum_in;
         run_ff   <= run_in;
      end
   end

endmodule

/* test/testbench.sv */
// Self-checking testbench of the countdown timer with its own timer predictor.
module testbench;
   import hms_pkg::*;

   localparam logic [SEL_W-1:0] SEL_UNUSED_LO = 3'd6;
   localparam logic [SEL_W-1:0] SEL_UNUSED_HI = 3'd7;
   localparam int unsigned LONG_HOLD_CYCLES = 120;
   localparam int unsigned PRINT_CAP = 100;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SEL_W-1:0]  sel;
   } timer_event_type;

   typedef struct packed {
      logic [HOUR_W-1:0] hours;
      logic [MIN_W-1:0]  minutes;
      logic [SEC_W-1:0]  seconds;
      logic              running;
   } timer_reading_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [TICK_W-1:0]     csr_data = '0;

   hms_countdown_timer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Predicted timer state.
   logic [HOUR_W-1:0] pred_hours;
   logic [MIN_W-1:0]  pred_minutes;
   logic [SEC_W-1:0]  pred_seconds;
   logic              pred_running;
   logic [TICK_W-1:0] pred_accum;
   logic [TICK_W-1:0] pred_period;

   timer_event_type   pending_events[$];
   timer_reading_type expected_readings[$];
   int unsigned       mismatch_count = 0;

   // Sender and receiver pacing.
   timer_event_type current_event;
   int unsigned  burst_left = 0;
   int unsigned  gap_left = 0;
   logic         sender_steady = 1'b0;
   int unsigned  hold_request = 0;
   int unsigned  hold_served = 0;
   int unsigned  hold_left = 0;
   int unsigned  pattern_age = 0;
   logic [15:0]  stall_pattern = '1;
   logic [3:0]   pattern_pos = '0;
   logic         ready_next;
   logic         offer_next;

   function automatic int unsigned tens_digit_step(int unsigned v, bit up, int unsigned top);
      if (up) return (v >= top) ? v - top : v + 10;
      return (v < 10) ? v + top : v - 10;
   endfunction

   function automatic int unsigned ones_digit_step(int unsigned v, bit up);
      if (up) return (v % 10 == 9) ? v - 9 : v + 1;
      return (v % 10 == 0) ? v + 9 : v - 1;
   endfunction

   function automatic timer_reading_type timer_advance(timer_event_type ev);
      timer_reading_type reading;
      bit up;
      up = (ev.kind == KIND_UP);
      case (ev.kind)
         KIND_TICK: begin
            if (pred_hours == 0 && pred_minutes == 0 && pred_seconds == 0) pred_running = 1'b0;
            if (pred_running) begin
               pred_accum = pred_accum + 1'b1;
               if (pred_accum >= pred_period) begin
                  pred_accum = '0;
                  if (pred_seconds == 0) begin
                     pred_seconds = SEC_W'(MS_RELOAD);
                     if (pred_minutes == 0) begin
                        pred_minutes = MIN_W'(MS_RELOAD);
                        pred_hours = pred_hours - 1'b1;
                     end else begin
                        pred_minutes = pred_minutes - 1'b1;
                     end
                  end else begin
                     pred_seconds = pred_seconds - 1'b1;
                  end
               end
            end
         end
         KIND_UP, KIND_DOWN: begin
            case (ev.sel)
               SEL_HOUR_TENS: pred_hours =
                  HOUR_W'(tens_digit_step(int'(pred_hours), up, HOUR_TENS_TOP));
               SEL_HOUR_ONES: pred_hours = HOUR_W'(ones_digit_step(int'(pred_hours), up));
               SEL_MIN_TENS:  pred_minutes =
                  MIN_W'(tens_digit_step(int'(pred_minutes), up, MS_TENS_TOP));
               SEL_MIN_ONES:  pred_minutes = MIN_W'(ones_digit_step(int'(pred_minutes), up));
               SEL_SEC_TENS:  pred_seconds =
                  SEC_W'(tens_digit_step(int'(pred_seconds), up, MS_TENS_TOP));
               SEL_SEC_ONES:  pred_seconds = SEC_W'(ones_digit_step(int'(pred_seconds), up));
               default: ;
            endcase
         end
         default: pred_running = ~pred_running;
      endcase
      reading.hours = pred_hours;
      reading.minutes = pred_minutes;
      reading.seconds = pred_seconds;
      reading.running = pred_running;
      return reading;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_reading(input logic [RSP_DATA_W-1:0] data);
      timer_reading_type want;
      timer_reading_type got;
      got.hours = data[HOUR_W-1:0];
      got.minutes = data[HOUR_W +: MIN_W];
      got.seconds = data[HOUR_W+MIN_W +: SEC_W];
      got.running = data[HOUR_W+MIN_W+SEC_W];
      if (expected_readings.size() == 0) begin
         report_mismatch("response transfer with no reading pending");
      end else begin
         want = expected_readings.pop_front();
         if (got.hours !== want.hours || got.minutes !== want.minutes ||
             got.seconds !== want.seconds || got.running !== want.running)
            report_mismatch($sformatf("got %0d:%0d:%0d run %0b, want %0d:%0d:%0d run %0b",
                                      got.hours, got.minutes, got.seconds, got.running,
                                      want.hours, want.minutes, want.seconds, want.running));
      end
   endtask

   // Driver: presents queued events in bursts and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         pred_hours = '0;
         pred_minutes = '0;
         pred_seconds = '0;
         pred_running = 1'b0;
         pred_accum = '0;
         pred_period = TPS_RESET;
      end else begin
         if (req_tvalid && req_tready) expected_readings.push_back(timer_advance(current_event));
         if (!req_tvalid || req_tready) begin
            offer_next = 1'b0;
            if (gap_left > 0 && !sender_steady) begin
               gap_left = gap_left - 1;
            end else if (pending_events.size() != 0) begin
               current_event = pending_events.pop_front();
               offer_next = 1'b1;
               if (burst_left > 1) begin
                  burst_left = burst_left - 1;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            req_tvalid <= offer_next;
            req_tdata <= {{(REQ_DATA_W-SEL_W){1'b0}}, current_event.sel};
            req_tuser <= current_event.kind;
         end
      end
   end

   // Monitor: checks each response transfer and paces rsp_tready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_reading(rsp_tdata);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            ready_next = 1'b0;
         end else if (hold_served != hold_request) begin
            hold_served = hold_request;
            hold_left = LONG_HOLD_CYCLES;
            ready_next = 1'b0;
         end else begin
            if (pattern_age == 0) begin
               pattern_age = $urandom_range(16, 80);
               stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
                               (16'($urandom) | 16'h0001);
            end else begin
               pattern_age = pattern_age - 1;
            end
            pattern_pos = pattern_pos + 1'b1;
            ready_next = stall_pattern[pattern_pos];
         end
         rsp_tready <= ready_next;
      end
   end

   task automatic queue_event(input logic [KIND_W-1:0] kind, input logic [SEL_W-1:0] sel);
      timer_event_type ev;
      ev.kind = kind;
      ev.sel = sel;
      pending_events.push_back(ev);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_tvalid || expected_readings.size() != 0);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_period(input logic [TICK_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      pred_period = value;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_random(input int unsigned count);
      int unsigned r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 62) queue_event(KIND_TICK, SEL_W'($urandom_range(0, 7)));
         else if (r < 75) queue_event(KIND_UP, SEL_W'($urandom_range(0, 7)));
         else if (r < 88) queue_event(KIND_DOWN, SEL_W'($urandom_range(0, 7)));
         else queue_event(KIND_TOGGLE, SEL_W'($urandom_range(0, 7)));
      end
   endtask

   // Steps the idle time down to a few seconds, starts it and ticks it through zero.
   task automatic queue_short_countdown(input int unsigned period);
      int unsigned secs;
      repeat (pred_hours % 10) queue_event(KIND_DOWN, SEL_HOUR_ONES);
      repeat (pred_hours / 10) queue_event(KIND_DOWN, SEL_HOUR_TENS);
      repeat (pred_minutes % 10) queue_event(KIND_DOWN, SEL_MIN_ONES);
      repeat (pred_minutes / 10) queue_event(KIND_DOWN, SEL_MIN_TENS);
      repeat (pred_seconds % 10) queue_event(KIND_DOWN, SEL_SEC_ONES);
      repeat (pred_seconds / 10) queue_event(KIND_DOWN, SEL_SEC_TENS);
      secs = $urandom_range(1, 9);
      repeat (secs) queue_event(KIND_UP, SEL_SEC_ONES);
      if (!pred_running) queue_event(KIND_TOGGLE, SEL_HOUR_TENS);
      repeat (secs * ((period == 0) ? 1 : period) + 2) queue_event(KIND_TICK, SEL_HOUR_TENS);
   endtask

   initial begin
      #3_000_000;
      $display("hms_countdown_timer regression: fail");
      $finish;
   end

   initial begin
      int unsigned period;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Start at zero time, stop on the next tick, then every digit wrap.
      queue_event(KIND_TOGGLE, SEL_HOUR_TENS);
      queue_event(KIND_TICK, SEL_HOUR_TENS);
      queue_event(KIND_TICK, SEL_SEC_ONES);
      queue_event(KIND_DOWN, SEL_HOUR_TENS);
      queue_event(KIND_DOWN, SEL_HOUR_ONES);
      queue_event(KIND_UP, SEL_HOUR_TENS);
      queue_event(KIND_UP, SEL_HOUR_ONES);
      queue_event(KIND_DOWN, SEL_MIN_TENS);
      queue_event(KIND_DOWN, SEL_MIN_ONES);
      queue_event(KIND_UP, SEL_MIN_TENS);
      queue_event(KIND_UP, SEL_MIN_ONES);
      queue_event(KIND_DOWN, SEL_SEC_TENS);
      queue_event(KIND_DOWN, SEL_SEC_ONES);
      queue_event(KIND_UP, SEL_SEC_TENS);
      queue_event(KIND_UP, SEL_SEC_ONES);
      queue_event(KIND_UP, SEL_UNUSED_LO);
      queue_event(KIND_DOWN, SEL_UNUSED_HI);
      wait_idle();

      // Count down to zero and stop, borrow from the hours, step while running.
      write_period(16'd1);
      queue_event(KIND_UP, SEL_SEC_ONES);
      queue_event(KIND_UP, SEL_SEC_ONES);
      queue_event(KIND_TOGGLE, SEL_HOUR_TENS);
      repeat (3) queue_event(KIND_TICK, SEL_HOUR_TENS);
      queue_event(KIND_UP, SEL_HOUR_ONES);
      queue_event(KIND_TOGGLE, SEL_HOUR_TENS);
      queue_event(KIND_TICK, SEL_HOUR_TENS);
      queue_event(KIND_UP, SEL_MIN_ONES);
      queue_event(KIND_TICK, SEL_HOUR_TENS);
      wait_idle();

      // A partial count under the widest period, then the period is lowered below it.
      write_period(16'hFFFF);
      repeat (4) queue_event(KIND_TICK, SEL_HOUR_TENS);
      wait_idle();
      write_period(16'd2);
      queue_event(KIND_TICK, SEL_HOUR_TENS);
      wait_idle();
      write_period(16'd0);
      repeat (2) queue_event(KIND_TICK, SEL_HOUR_TENS);
      wait_idle();

      for (int p = 0; p < 11; p++) begin
         case (p)
            0: period = 1;
            1: period = 16'hFFFF;
            2: period = 1000;
            default: period = (p % 4 == 3) ? $urandom_range(4, 30) : $urandom_range(1, 3);
         endcase
         write_period(period[TICK_W-1:0]);
         if (p == 5) begin
            sender_steady <= 1'b1;
            hold_request <= hold_request + 1;
            repeat (60) queue_event(KIND_TICK, SEL_W'($urandom_range(0, 7)));
            queue_random(20);
         end else begin
            if (period <= 3 && $urandom_range(0, 1) == 0) queue_short_countdown(period);
            queue_random(35);
         end
         wait_idle();
         sender_steady <= 1'b0;
      end

      repeat (10) @(negedge clock);
      if (expected_readings.size() != 0)
         report_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));
      if (mismatch_count == 0) begin
         $display("hms_countdown_timer regression: pass");
      end else begin
         $display("hms_countdown_timer regression: fail");
      end
      $finish;
   end

endmodule

/* hms_countdown_timer.f */
hdl/hms_pkg.sv
hdl/hms_digit_cell.sv
hdl/hms_tick_ctrl.sv
hdl/hms_countdown_timer.sv
test/testbench.sv
